/* rtl/afl_pkg.sv */
package afl_pkg;

  localparam int unsigned DELAY_LENGTH    = 8;
  localparam int unsigned CHANNELS        = 2;
  localparam int unsigned SINE_TABLE_SIZE = 256;
  localparam int unsigned SINE_TABLE_BITS = $clog2(SINE_TABLE_SIZE);

  // Keeps only the phase bits that select a sine table position.
  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned GAIN_W     = 17;

  localparam logic [GAIN_W-1:0] Q_ONE     = 17'd65536;
  localparam logic [GAIN_W-1:0] WET_RESET = 17'd32768;
  localparam logic [GAIN_W-1:0] SIN_A     = 17'd102944;
  localparam logic [GAIN_W-1:0] SIN_B     = 17'd42048;
  localparam logic [GAIN_W-1:0] SIN_C     = 17'd4640;
  localparam logic [GAIN_W-1:0] FB_SCALE  = 17'd55706;

  localparam int unsigned MUL_A_W = 19;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    CFG_LFO_STEP      = 2'd0,
    CFG_SWEEP_DEPTH   = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2,
    CFG_WET_MIX       = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X2,
    ST_CX2,
    ST_BT,
    ST_AT,
    ST_DEPTH,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_DLY,
    ST_MIXDRY,
    ST_STORE,
    ST_OUT
  } state_e;

endpackage

/* rtl/afl_if.sv */
interface afl_in_if;
  logic               valid;
  logic               ready;
  logic               channel;
  logic signed [15:0] in_sample;

  modport source (output valid, output channel, output in_sample, input ready);
  modport sink (input valid, input channel, input in_sample, output ready);
endinterface

interface afl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

/* rtl/afl_mul.sv */
module afl_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [afl_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [afl_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [afl_pkg::PROD_W-1:0]   p_o
);

  logic signed [afl_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= afl_pkg::PROD_W'(a_i) * afl_pkg::PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/audio_flanger_feedback.sv */
// Channel  Direction  Handshake          Payload
// in_i     sink       valid / ready      channel, in_sample
// out_o    source     valid / ready      out_sample
// cfg      write      cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One sample passes through eleven steps of a single shared 19 x 18 multiplier and an
// output step, sequenced by a small state machine, after the accept step; a new sample
// is taken only once the previous one has left the output step.
// The ring memory has one read port, so the two interpolation taps are read in turn.
// Reset is asynchronous and active low; ring entries not yet written read as zero.
// A result waits in the output register; the next sample is taken meanwhile, and only
// the final step stalls while that register is still full.
module audio_flanger_feedback #(
  parameter int unsigned DELAY_LENGTH = afl_pkg::DELAY_LENGTH,
  parameter int unsigned CHANNELS     = afl_pkg::CHANNELS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  afl_in_if.sink                             in_i,
  afl_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [afl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [afl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(DELAY_LENGTH);
  localparam int unsigned FW    = $clog2(DELAY_LENGTH + 1);
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth = CHANNELS * DELAY_LENGTH;
  localparam int unsigned MW    = $clog2(Depth);
  localparam int unsigned PW    = afl_pkg::PROD_W;
  localparam int unsigned SW    = PW + 2;
  localparam int unsigned RW    = SW - 16;
  localparam int unsigned GW    = afl_pkg::GAIN_W;
  localparam int unsigned AMW   = afl_pkg::MUL_A_W;
  localparam int unsigned BMW   = afl_pkg::MUL_B_W;

  localparam logic [AW:0]            DlExt    = (AW + 1)'(DELAY_LENGTH);
  localparam logic [AW-1:0]          LastIdx  = AW'(DELAY_LENGTH - 1);
  localparam logic [FW-1:0]          FillFull = FW'(DELAY_LENGTH);
  localparam logic signed [SW-1:0]   Half     = SW'(32768);
  localparam logic signed [RW-1:0]   SatMax   = RW'(32767);
  localparam logic signed [RW-1:0]   SatMin   = RW'(-32768);

  function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
    logic signed [15:0] r;
    if (v > SatMax) begin
      r = 16'sh7fff;
    end else if (v < SatMin) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [GW-1:0] sat_gain(input logic [GW-1:0] v);
    return (v > afl_pkg::Q_ONE) ? afl_pkg::Q_ONE : v;
  endfunction

  function automatic logic signed [AMW-1:0] ua(input logic [17:0] v);
    return $signed(AMW'(v));
  endfunction

  function automatic logic signed [AMW-1:0] sa(input logic signed [15:0] v);
    return AMW'(v);
  endfunction

  function automatic logic signed [BMW-1:0] ub(input logic [GW-1:0] v);
    return $signed(BMW'(v));
  endfunction

  afl_pkg::state_e state_q, state_d;

  logic [31:0]    lfo_step_q;
  logic [GW-1:0]  depth_q;
  logic [GW-1:0]  fbg_q;
  logic [GW-1:0]  mix_q;

  logic [31:0]    phase_q [CHANNELS];
  logic [AW-1:0]  wp_q    [CHANNELS];
  logic [FW-1:0]  fill_q  [CHANNELS];

  logic [CW-1:0]       ch_q;
  logic signed [15:0]  x_q;
  logic [1:0]          quad_q;
  logic [GW-1:0]       xs_q;
  logic [GW-1:0]       x2_q;
  logic [AW-1:0]       i1_q;
  logic [15:0]         frac_q;
  logic [15:0]         fb_q;
  logic signed [PW-1:0] acc_q;
  logic signed [15:0]  delayed_q;
  logic signed [15:0]  out_q;
  logic                out_vld_q;

  logic signed [15:0]  ring_mem [Depth];
  logic signed [15:0]  mem_rd_q;
  logic                rd_ok_q;

  logic                  in_acc;
  logic                  out_free;
  logic [CW-1:0]         ch_in;
  logic [31:0]           phase_in;
  logic [31:0]           phase_msk;
  logic [15:0]           xq_in;
  logic [GW-1:0]         xs_in;

  logic                  mul_en;
  logic signed [AMW-1:0] mul_a;
  logic signed [BMW-1:0] mul_b;
  logic signed [PW-1:0]  p;
  logic [PW-17:0]        p_hi;

  logic [GW-1:0]         t1;
  logic [GW-1:0]         t2;
  logic [GW-1:0]         s_mag;
  logic signed [17:0]    sine;
  logic signed [18:0]    u_sum;
  logic [GW-1:0]         u;
  logic [17:0]           depth3;
  logic [18:0]           dly;
  logic [AW:0]           t_idx;
  logic [AW-1:0]         i0;
  logic [AW-1:0]         i1;
  logic [15:0]           frac_w;
  logic [AW-1:0]         wp_cur;
  logic signed [15:0]    rd_val;

  logic signed [SW-1:0]  acc_sum;
  logic signed [SW-1:0]  p_sum;
  logic signed [RW-1:0]  rnd_acc;
  logic signed [RW-1:0]  rnd_p;
  logic signed [15:0]    stored;
  logic signed [15:0]    result;

  logic                  mem_re;
  logic                  mem_we;
  logic [AW-1:0]         rd_idx;
  logic [MW-1:0]         base;
  logic [MW-1:0]         rd_addr;
  logic [MW-1:0]         wr_addr;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  assign in_i.ready       = (state_q == afl_pkg::ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.out_sample = out_q;

  // LFO phase is reduced to a table position, then to a quadrant and a Q16 offset.
  assign ch_in     = (CHANNELS > 1) ? CW'(in_i.channel) : '0;
  assign phase_in  = phase_q[ch_in];
  assign phase_msk = phase_in & afl_pkg::PHASE_MASK;
  assign xq_in     = phase_msk[29:14];
  assign xs_in     = phase_in[30] ? (afl_pkg::Q_ONE - GW'(xq_in)) : GW'(xq_in);

  afl_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  assign p_hi   = p[PW-1:16];
  assign t1     = afl_pkg::SIN_B - GW'(p_hi);
  assign t2     = afl_pkg::SIN_A - GW'(p_hi);
  assign s_mag  = (p_hi > (PW - 16)'(afl_pkg::Q_ONE)) ? afl_pkg::Q_ONE : GW'(p_hi);
  assign sine   = quad_q[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign u_sum  = 19'(sine) + 19'sd65536;
  assign u      = u_sum[17:1];
  assign depth3 = 18'(depth_q) + (18'(depth_q) << 1);

  // Read position: write index minus the Q16 delay, modulo the ring length.
  assign dly    = 19'(afl_pkg::Q_ONE) + 19'(p_hi);
  assign wp_cur = wp_q[ch_q];
  assign t_idx  = (AW + 1)'(wp_cur) + DlExt - (AW + 1)'(dly[18:16])
                - (AW + 1)'(dly[15:0] != 16'd0);
  assign i0     = (t_idx >= DlExt) ? AW'(t_idx - DlExt) : AW'(t_idx);
  assign i1     = (i0 == LastIdx) ? '0 : i0 + AW'(1);
  assign frac_w = ~dly[15:0] + 16'd1;

  assign rd_val  = rd_ok_q ? mem_rd_q : '0;
  assign acc_sum = SW'(acc_q) + SW'(p) + Half;
  assign p_sum   = SW'(p) + Half;
  assign rnd_acc = acc_sum[SW-1:16];
  assign rnd_p   = p_sum[SW-1:16];
  assign stored  = sat16(rnd_p + RW'(x_q));
  assign result  = sat16(rnd_acc);

  assign base    = MW'(int'(ch_q) * DELAY_LENGTH);
  assign rd_idx  = (state_q == afl_pkg::ST_ADDR) ? i0 : i1_q;
  assign rd_addr = base + MW'(rd_idx);
  assign wr_addr = base + MW'(wp_cur);

  always_comb begin
    state_d = state_q;
    mul_en  = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    case (state_q)
      afl_pkg::ST_IDLE: begin
        mul_en = 1'b0;
        if (in_acc) begin
          state_d = afl_pkg::ST_X2;
        end
      end
      afl_pkg::ST_X2: begin
        mul_a   = ua(18'(xs_q));
        mul_b   = ub(xs_q);
        state_d = afl_pkg::ST_CX2;
      end
      afl_pkg::ST_CX2: begin
        mul_a   = ua(18'(afl_pkg::SIN_C));
        mul_b   = ub(GW'(p_hi));
        state_d = afl_pkg::ST_BT;
      end
      afl_pkg::ST_BT: begin
        mul_a   = ua(18'(t1));
        mul_b   = ub(x2_q);
        state_d = afl_pkg::ST_AT;
      end
      afl_pkg::ST_AT: begin
        mul_a   = ua(18'(t2));
        mul_b   = ub(xs_q);
        state_d = afl_pkg::ST_DEPTH;
      end
      afl_pkg::ST_DEPTH: begin
        mul_a   = ua(depth3);
        mul_b   = ub(u);
        state_d = afl_pkg::ST_ADDR;
      end
      afl_pkg::ST_ADDR: begin
        mem_re  = 1'b1;
        mul_a   = ua(18'(fbg_q));
        mul_b   = ub(afl_pkg::FB_SCALE);
        state_d = afl_pkg::ST_RD0;
      end
      afl_pkg::ST_RD0: begin
        mem_re  = 1'b1;
        mul_a   = sa(rd_val);
        mul_b   = ub(afl_pkg::Q_ONE - GW'(frac_q));
        state_d = afl_pkg::ST_RD1;
      end
      afl_pkg::ST_RD1: begin
        mul_a   = sa(rd_val);
        mul_b   = ub(GW'(frac_q));
        state_d = afl_pkg::ST_DLY;
      end
      afl_pkg::ST_DLY: begin
        mul_a   = sa(x_q);
        mul_b   = ub(afl_pkg::Q_ONE - mix_q);
        state_d = afl_pkg::ST_MIXDRY;
      end
      afl_pkg::ST_MIXDRY: begin
        mul_a   = sa(delayed_q);
        mul_b   = ub(GW'(fb_q));
        state_d = afl_pkg::ST_STORE;
      end
      afl_pkg::ST_STORE: begin
        mem_we  = 1'b1;
        mul_a   = sa(delayed_q);
        mul_b   = ub(mix_q);
        state_d = afl_pkg::ST_OUT;
      end
      afl_pkg::ST_OUT: begin
        mul_en = 1'b0;
        if (out_free) begin
          state_d = afl_pkg::ST_IDLE;
        end
      end
      default: begin
        mul_en  = 1'b0;
        state_d = afl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_step_q <= '0;
      depth_q    <= '0;
      fbg_q      <= '0;
      mix_q      <= afl_pkg::WET_RESET;
    end else if (cfg_we_i) begin
      case (afl_pkg::cfg_idx_e'(cfg_idx_i))
        afl_pkg::CFG_LFO_STEP:      lfo_step_q <= cfg_wdata_i;
        afl_pkg::CFG_SWEEP_DEPTH:   depth_q    <= sat_gain(cfg_wdata_i[GW-1:0]);
        afl_pkg::CFG_FEEDBACK_GAIN: fbg_q      <= sat_gain(cfg_wdata_i[GW-1:0]);
        afl_pkg::CFG_WET_MIX:       mix_q      <= sat_gain(cfg_wdata_i[GW-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Entries are written in order from index zero, so a fill count per channel tells
  // which ring entries have not yet been written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase_q[c] <= '0;
        wp_q[c]    <= '0;
        fill_q[c]  <= '0;
      end
    end else if (state_q == afl_pkg::ST_STORE) begin
      phase_q[ch_q] <= phase_q[ch_q] + lfo_step_q;
      wp_q[ch_q]    <= (wp_cur == LastIdx) ? '0 : wp_cur + AW'(1);
      if (fill_q[ch_q] != FillFull) begin
        fill_q[ch_q] <= fill_q[ch_q] + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == afl_pkg::ST_OUT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= ch_in;
      x_q    <= in_i.in_sample;
      quad_q <= phase_in[31:30];
      xs_q   <= xs_in;
    end
    case (state_q)
      afl_pkg::ST_CX2: x2_q <= GW'(p_hi);
      afl_pkg::ST_ADDR: begin
        i1_q   <= i1;
        frac_q <= frac_w;
      end
      afl_pkg::ST_RD0: fb_q <= 16'(p_hi);
      afl_pkg::ST_RD1: acc_q <= p;
      afl_pkg::ST_DLY: delayed_q <= rnd_acc[15:0];
      afl_pkg::ST_MIXDRY: acc_q <= p;
      afl_pkg::ST_OUT: begin
        if (out_free) begin
          out_q <= result;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= stored;
    end
    if (mem_re) begin
      mem_rd_q <= ring_mem[rd_addr];
      rd_ok_q  <= (FW'(rd_idx) < fill_q[ch_q]);
    end
  end

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##12 (state_q == afl_pkg::ST_OUT))
    else $error("Sample did not reach the final step after twelve cycles.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afl_pkg::ST_OUT && out_free) |=> (out_vld_q && state_q == afl_pkg::ST_IDLE))
    else $error("Finished result was not placed in the output register.");

  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afl_pkg::ST_STORE) |-> (fill_q[ch_q] <= FillFull && wp_cur <= LastIdx))
    else $error("Ring write index or fill count out of range.");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam longint UNITY = 65536;
  localparam longint HALF = 32768;
  localparam longint RING = afl_pkg::DELAY_LENGTH;
  localparam longint TABLE = afl_pkg::SINE_TABLE_SIZE;
  localparam longint SINE_A = afl_pkg::SIN_A;
  localparam longint SINE_B = afl_pkg::SIN_B;
  localparam longint SINE_C = afl_pkg::SIN_C;
  localparam longint FB_K = afl_pkg::FB_SCALE;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [31:0] GAIN_ALL_ONES = 32'h0001_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  afl_pkg::cfg_idx_e cfg_idx_i;
  logic [afl_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  afl_in_if in_if ();
  afl_out_if out_if ();

  audio_flanger_feedback DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic signed [15:0] ring_r [afl_pkg::CHANNELS][afl_pkg::DELAY_LENGTH] = '{default: '0};
  int write_idx_r [afl_pkg::CHANNELS] = '{default: 0};
  logic [31:0] lfo_phase_r [afl_pkg::CHANNELS] = '{default: '0};
  logic [31:0] lfo_step_r = '0;
  logic [16:0] sweep_depth_r = '0;
  logic [16:0] feedback_gain_r = '0;
  logic [16:0] wet_mix_r = afl_pkg::WET_RESET;

  logic signed [15:0] expected_out_q [$];
  int errors = 0;
  int cycle_count = 0;
  int hold_off_cycles = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint quarter_wave(input longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 16;
    t = (SINE_C * x2) >>> 16;
    t = SINE_B - t;
    t = (t * x2) >>> 16;
    t = SINE_A - t;
    t = (t * x) >>> 16;
    return (t > UNITY) ? UNITY : t;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint gain_limit(input logic [16:0] g);
    return (g > afl_pkg::Q_ONE) ? UNITY : longint'(g);
  endfunction

  // Works out one flanged sample and advances the channel's ring, pointer and phase.
  function automatic logic signed [15:0] flange_sample(input int ch,
                                                       input logic signed [15:0] smp);
    longint dry, pos, q, quad, x, sine, lfo_u, delay_q16, rd_pos, frac;
    longint tap0, tap1, wet, depth, fb_q16, mix, stored, mixed;
    int wp, idx0, idx1;
    dry = smp;
    depth = gain_limit(sweep_depth_r);
    fb_q16 = (gain_limit(feedback_gain_r) * FB_K) >>> 16;
    mix = gain_limit(wet_mix_r);
    wp = write_idx_r[ch] % afl_pkg::DELAY_LENGTH;

    pos = (longint'(lfo_phase_r[ch]) * TABLE) >>> 32;
    q = (pos * 4 * UNITY) / TABLE;
    quad = (q >>> 16) & 3;
    x = q & 16'hFFFF;
    case (quad)
      0: sine = quarter_wave(x);
      1: sine = quarter_wave(UNITY - x);
      2: sine = -quarter_wave(x);
      default: sine = -quarter_wave(UNITY - x);
    endcase

    lfo_u = (sine + UNITY) >>> 1;
    delay_q16 = UNITY + ((3 * depth * lfo_u) >>> 16);
    rd_pos = ((longint'(wp) << 16) + (RING << 16) - delay_q16) % (RING << 16);
    idx0 = int'((rd_pos >>> 16) % RING);
    idx1 = (idx0 + 1) % afl_pkg::DELAY_LENGTH;
    frac = rd_pos & 16'hFFFF;

    tap0 = ring_r[ch][idx0];
    tap1 = ring_r[ch][idx1];
    wet = (tap0 * (UNITY - frac) + tap1 * frac + HALF) >>> 16;
    stored = dry + ((wet * fb_q16 + HALF) >>> 16);
    ring_r[ch][wp] = clip16(stored);
    mixed = (dry * (UNITY - mix) + wet * mix + HALF) >>> 16;

    write_idx_r[ch] = (wp + 1) % afl_pkg::DELAY_LENGTH;
    lfo_phase_r[ch] = lfo_phase_r[ch] + lfo_step_r;
    return clip16(mixed);
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic ch, input logic signed [15:0] smp);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.channel <= ch;
    in_if.in_sample <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    expected_out_q.push_back(flange_sample(int'(ch) % afl_pkg::CHANNELS, smp));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] step, input logic [31:0] depth,
                              input logic [31:0] fb, input logic [31:0] mix);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= afl_pkg::CFG_LFO_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_idx_i <= afl_pkg::CFG_SWEEP_DEPTH;
    cfg_wdata_i <= depth;
    @(posedge clk_i);
    cfg_idx_i <= afl_pkg::CFG_FEEDBACK_GAIN;
    cfg_wdata_i <= fb;
    @(posedge clk_i);
    cfg_idx_i <= afl_pkg::CFG_WET_MIX;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lfo_step_r = step;
    sweep_depth_r = depth[16:0];
    feedback_gain_r = fb[16:0];
    wet_mix_r = mix[16:0];
  endtask

  task automatic test_reset_defaults();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_sample(1'b0, 16'sh7FFF);
    send_sample(1'b1, -16'sh8000);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'sd1);
    send_sample(1'b1, 16'sh7FFF);
  endtask

  task automatic test_gain_limits();
    // Settings above unity must behave as unity; full feedback drives the ring into clipping.
    program_regs(32'hFFFF_FFFF, GAIN_ALL_ONES, GAIN_ALL_ONES, GAIN_ALL_ONES);
    repeat (4) send_sample(1'b0, 16'sh7FFF);
    repeat (4) send_sample(1'b1, -16'sh8000);
    program_regs(32'd0, 32'd0, 32'd0, 32'd0);
    send_sample(1'b0, -16'sh8000);
    send_sample(1'b1, 16'sh7FFF);
    send_sample(1'b0, -16'sd2);
    send_sample(1'b1, 16'sd16384);
    program_regs(32'h0100_0000, 32'd65536, 32'd65536, 32'd65536);
    for (int i = 0; i < 6; i++) begin
      send_sample(i[0], i[1] ? 16'sh7FFF : -16'sh8000);
    end
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_off_cycles = 300;
    repeat (40) send_sample(1'($urandom_range(0, 1)), pick_sample());
  endtask

  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (5) begin
      repeat (10) send_sample(1'($urandom_range(0, 1)), pick_sample());
      wait_drained();
    end
  endtask

  task automatic test_random_sweep();
    logic [31:0] step;
    for (int p = 0; p < 8; p++) begin
      step = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      case (p)
        0: program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        1: program_regs(32'hFFFF_FFFF, GAIN_ALL_ONES, GAIN_ALL_ONES, GAIN_ALL_ONES);
        default: program_regs(step, pick_gain(), pick_gain(), pick_gain());
      endcase
      tx_idle_en = (p != 2) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p != 2) && ($urandom_range(0, 3) != 0);
      repeat (190) send_sample(1'($urandom_range(0, 1)), pick_sample());
    end
  endtask

  initial begin
    int gap;
    logic signed [15:0] want;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (expected_out_q.size() == 0) begin
        $error("out_sample: expected none, actual %0d", out_if.out_sample);
        errors++;
      end else begin
        want = expected_out_q.pop_front();
        if (out_if.out_sample !== want) begin
          $error("out_sample: expected %0d, actual %0d", want, out_if.out_sample);
          errors++;
        end
      end
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.channel <= 1'b0;
    in_if.in_sample <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= afl_pkg::CFG_LFO_STEP;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_gain_limits();
    test_output_backpressure();
    test_sender_pause();
    test_random_sweep();
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
